// ===== hdl/rbs_pkg.sv =====
// Shared types and constants for the ranked byte sequence core.
// Holds the command and result kind codes, the controller states and the stream field widths.
// Depends on nothing; the core top level and the checker import it.
package rbs_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned RANK_W   = 7;
    localparam int unsigned ELEM_W   = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned VALUE_W  = 8;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_DEL   = 2'd1,
        CMD_GET   = 2'd2,
        CMD_PRINT = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INV   = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_GET   = 2'd2,
        KIND_PRINT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DRAIN,
        ST_INS_WR,
        ST_GET,
        ST_PRINT,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/rbs_ram.sv =====
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Used as the entry store of the ranked byte sequence core. No dependencies.
module rbs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/ranked_byte_sequence_core.sv =====
// Top level of the ranked byte sequence core: controller, count register and output register.
// Depends on rbs_pkg and on rbs_ram, which holds the entries.
//
//   channel  | direction | tdata fields (low bit up) | tuser | tlast
//   s_       | in        | rank[6:0], elem[14:7]     | cmd   | unused
//   m_       | out       | value[7:0]                | kind  | last
//
// One item is worked at a time; the entry RAM has one read and one write port.
// An add at rank r shifts the entries from rank r up by one and then writes the element,
// or appends it directly; a delete shifts the later entries down, or only counts at the tail.
// A get reads one entry, an error emits one beat; a print stalls while m_tready is low.
// Reset is synchronous and active low; the entries need no clearing.
module ranked_byte_sequence_core
    import rbs_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // rank[6:0], elem[14:7], zero[15]
    input  logic [CMD_W-1:0]    s_tuser,   // cmd[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // value[7:0]
    output logic [KIND_W-1:0]   m_tuser,   // kind[1:0]
    output logic                m_tlast
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      stop_reg, stop_next;
    logic               up_reg, up_next;
    logic               wv_reg, wv_next;
    logic [AW-1:0]      wa_reg, wa_next;
    logic               rv_reg, rv_next;
    logic [ELEM_W-1:0]  elem_reg, elem_next;
    logic [AW-1:0]      ins_reg, ins_next;
    kind_t              res_kind_reg, res_kind_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;

    logic               m_valid_reg, m_valid_next;
    kind_t              m_kind_reg, m_kind_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic               m_last_reg, m_last_next;

    logic               ram_we;
    logic [AW-1:0]      ram_wa;
    logic [ELEM_W-1:0]  ram_wd;
    logic [AW-1:0]      ram_ra;
    logic [ELEM_W-1:0]  ram_rd;

    logic [RANK_W-1:0]  in_rank;
    logic [ELEM_W-1:0]  in_elem;
    cmd_t               in_cmd;
    logic [7:0]         rank_w;
    logic [7:0]         cnt_w;
    logic [RANK_W-1:0]  rank_m1;
    logic [AW-1:0]      last_idx;
    logic               out_free;

    assign in_rank  = s_tdata[RANK_W-1:0];
    assign in_elem  = s_tdata[RANK_W+ELEM_W-1:RANK_W];
    assign in_cmd   = cmd_t'(s_tuser);
    assign rank_w   = {1'b0, in_rank};
    assign cnt_w    = 8'(count_reg);
    assign rank_m1  = in_rank - RANK_W'(1);
    assign last_idx = AW'(count_reg - CW'(1));
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    rbs_ram #(
        .WIDTH(ELEM_W),
        .DEPTH(CAPACITY)
    ) u_rbs_ram (
        .clk    (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_wa),
        .wr_data(ram_wd),
        .rd_addr(ram_ra),
        .rd_data(ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            wv_reg      <= 1'b0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wv_reg      <= wv_next;
            rv_reg      <= rv_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg       <= ptr_next;
        stop_reg      <= stop_next;
        up_reg        <= up_next;
        wa_reg        <= wa_next;
        elem_reg      <= elem_next;
        ins_reg       <= ins_next;
        res_kind_reg  <= res_kind_next;
        res_value_reg <= res_value_next;
        m_kind_reg    <= m_kind_next;
        m_value_reg   <= m_value_next;
        m_last_reg    <= m_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        stop_next      = stop_reg;
        up_next        = up_reg;
        wv_next        = wv_reg;
        wa_next        = wa_reg;
        rv_next        = rv_reg;
        elem_next      = elem_reg;
        ins_next       = ins_reg;
        res_kind_next  = res_kind_reg;
        res_value_next = res_value_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_value_next   = m_value_reg;
        m_last_next    = m_last_reg;
        ram_we         = wv_reg;
        ram_wa         = wa_reg;
        ram_wd         = ram_rd;
        ram_ra         = ptr_reg;

        case (state_reg)
            ST_IDLE: begin
                ram_ra = AW'(rank_m1);
                if (s_tvalid) begin
                    case (in_cmd)
                        CMD_ADD: begin
                            if (rank_w == 8'd0 || rank_w > cnt_w + 8'd1) begin
                                res_kind_next  = KIND_INV;
                                res_value_next = '0;
                                state_next     = ST_EMIT;
                            end else if (count_reg == CW'(CAPACITY)) begin
                                res_kind_next  = KIND_FULL;
                                res_value_next = '0;
                                state_next     = ST_EMIT;
                            end else begin
                                count_next = count_reg + CW'(1);
                                elem_next  = in_elem;
                                ins_next   = AW'(rank_m1);
                                if (rank_w == cnt_w + 8'd1) begin
                                    state_next = ST_INS_WR;
                                end else begin
                                    ptr_next   = last_idx;
                                    stop_next  = AW'(rank_m1);
                                    up_next    = 1'b1;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        CMD_DEL: begin
                            if (rank_w == 8'd0 || rank_w > cnt_w) begin
                                res_kind_next  = KIND_INV;
                                res_value_next = '0;
                                state_next     = ST_EMIT;
                            end else begin
                                count_next = count_reg - CW'(1);
                                if (rank_w != cnt_w) begin
                                    ptr_next   = AW'(in_rank);
                                    stop_next  = last_idx;
                                    up_next    = 1'b0;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        CMD_GET: begin
                            if (rank_w == 8'd0 || rank_w > cnt_w) begin
                                res_kind_next  = KIND_INV;
                                res_value_next = '0;
                                state_next     = ST_EMIT;
                            end else begin
                                state_next = ST_GET;
                            end
                        end
                        default: begin
                            if (count_reg != '0) begin
                                ptr_next   = '0;
                                rv_next    = 1'b0;
                                state_next = ST_PRINT;
                            end
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                wv_next = 1'b1;
                wa_next = up_reg ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                if (ptr_reg == stop_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    ptr_next = up_reg ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                wv_next    = 1'b0;
                state_next = up_reg ? ST_INS_WR : ST_IDLE;
            end
            ST_INS_WR: begin
                ram_we     = 1'b1;
                ram_wa     = ins_reg;
                ram_wd     = elem_reg;
                state_next = ST_IDLE;
            end
            ST_GET: begin
                if (ram_rd == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    res_kind_next  = KIND_GET;
                    res_value_next = ram_rd;
                    state_next     = ST_EMIT;
                end
            end
            ST_PRINT: begin
                if (!rv_reg) begin
                    rv_next = 1'b1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_PRINT;
                    m_value_next = ram_rd;
                    m_last_next  = (ptr_reg == last_idx);
                    if (ptr_reg == last_idx) begin
                        rv_next    = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next = ptr_reg + AW'(1);
                        ram_ra   = ptr_reg + AW'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_value_next = res_value_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/rbs_check.sv =====
// Port-level assertions for the ranked byte sequence core, bound to the top level.
// Depends on rbs_pkg for the result kind codes.
module rbs_check
    import rbs_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]   m_tuser,
    input logic                m_tlast
);

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result beat dropped while stalled.");

    a_reset_quiet: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid)
        else $error("Result beat shown right after reset.");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_PRINT |-> m_tlast)
        else $error("Single-result beat without last.");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_INV || m_tuser == KIND_FULL) |-> m_tdata == '0)
        else $error("Error beat carries a nonzero value.");

    a_get_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_GET |-> m_tdata != '0)
        else $error("Get beat carries a zero byte.");

endmodule

bind ranked_byte_sequence_core rbs_check u_rbs_check (.*);
